### rtl/core/assert_macros.svh
// Assertion macros for the checker file.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check at every rising edge, muted while reset is low.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Check at every rising edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

### rtl/core/b64se_pkg.sv
// Package for the Base64 stream encoder: item types, group descriptor, alphabet.
// No dependencies.
package b64se_pkg;

    localparam logic [7:0] PadChar = 8'h3D;
    localparam int         QDepth  = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } t_out_item;

    // One 24-bit group ready for output, with padding count and end mark.
    typedef struct packed {
        logic [23:0] bits;
        logic [1:0]  pad;
        logic        last;
    } t_group;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_status;

    function automatic logic [7:0] b64_char(input logic [5:0] s);
        logic [7:0] c;
        if (s < 6'd26) begin
            c = 8'd65 + {2'b00, s};
        end else if (s < 6'd52) begin
            c = 8'd71 + {2'b00, s};
        end else if (s < 6'd62) begin
            c = {2'b00, s} - 8'd4;
        end else if (s == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

endpackage

### rtl/core/base64_stream_encoder_unit.sv
// Top level of the Base64 stream encoder.
// Depends on b64se_pkg, b64se_front, b64se_queue, b64se_back.
//
// Input channel: raw bytes with an end-of-message flag; an item enters on a
// rising edge with i_push high and o_full low. Result channel: one Base64
// character (or '=') per item with a last-character flag; the oldest result
// shows while o_empty is low and leaves on an edge with i_pop high.
// Bytes that do not close a group are only held and give no result. A byte
// that closes a group (third byte, or any byte marked end of message) yields
// four characters; o_empty falls once the group has gone through the queue,
// r_grp and r_out, and the rest follow one per cycle while i_pop stays high.
// Throughput: bytes enter one per cycle while the two-group queue has room;
// sustained, three bytes per four characters, set by the single output
// register that the back end fills one character a cycle while i_pop is high.
// Reset (synchronous, i_rst_n low) drops held bytes, queued groups and the
// waiting result. When the receiver stalls, the result holds, the back end
// stops, the queue fills, and o_full then holds off the sender.
module base64_stream_encoder_unit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64se_pkg::t_in_item  i_in_item,
    output logic                 o_full,
    input  logic                 i_pop,
    output logic                 o_empty,
    output b64se_pkg::t_out_item o_out_item
);
    import b64se_pkg::*;

    t_group    grp_wdata, grp_rdata;
    t_q_status q_status;
    logic      grp_push, grp_pop;

    b64se_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (i_push),
        .i_in_item  (i_in_item),
        .i_q_status (q_status),
        .o_full     (o_full),
        .o_grp_push (grp_push),
        .o_grp      (grp_wdata)
    );

    b64se_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_wr     (grp_push),
        .i_wdata  (grp_wdata),
        .i_rd     (grp_pop),
        .o_rdata  (grp_rdata),
        .o_status (q_status)
    );

    b64se_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_grp      (grp_rdata),
        .i_q_status (q_status),
        .o_grp_pop  (grp_pop),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_out_item (o_out_item)
    );

endmodule

### rtl/core/b64se_front.sv
// Front end: accepts bytes, holds up to two, and forms complete or padded groups.
// Depends on b64se_pkg.
module b64se_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  b64se_pkg::t_in_item  i_in_item,
    input  b64se_pkg::t_q_status i_q_status,
    output logic                 o_full,
    output logic                 o_grp_push,
    output b64se_pkg::t_group    o_grp
);
    import b64se_pkg::*;

    logic [15:0] r_pend, n_pend;
    logic [1:0]  r_cnt, n_cnt;
    logic        accept;

    assign o_full = i_q_status.full;
    assign accept = i_push && !i_q_status.full;

    always_comb begin
        n_pend     = r_pend;
        n_cnt      = r_cnt;
        o_grp_push = 1'b0;
        o_grp      = '0;
        if (accept) begin
            case (r_cnt)
                2'd2: begin
                    o_grp_push = 1'b1;
                    o_grp.bits = {r_pend, i_in_item.data_byte};
                    o_grp.pad  = 2'd0;
                    o_grp.last = i_in_item.end_of_message;
                    n_pend     = '0;
                    n_cnt      = 2'd0;
                end
                2'd1: begin
                    if (i_in_item.end_of_message) begin
                        o_grp_push = 1'b1;
                        o_grp.bits = {r_pend[7:0], i_in_item.data_byte, 8'h00};
                        o_grp.pad  = 2'd1;
                        o_grp.last = 1'b1;
                        n_pend     = '0;
                        n_cnt      = 2'd0;
                    end else begin
                        n_pend = {r_pend[7:0], i_in_item.data_byte};
                        n_cnt  = 2'd2;
                    end
                end
                default: begin
                    // empty count, and the unreachable count of three, start a fresh group
                    if (i_in_item.end_of_message) begin
                        o_grp_push = 1'b1;
                        o_grp.bits = {i_in_item.data_byte, 16'h0000};
                        o_grp.pad  = 2'd2;
                        o_grp.last = 1'b1;
                        n_pend     = '0;
                        n_cnt      = 2'd0;
                    end else begin
                        n_pend = {8'h00, i_in_item.data_byte};
                        n_cnt  = 2'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
            r_cnt  <= '0;
        end else begin
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

### rtl/core/b64se_queue.sv
// Two-entry group queue between front and back ends.
// Depends on b64se_pkg.
module b64se_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_wr,
    input  b64se_pkg::t_group    i_wdata,
    input  logic                 i_rd,
    output b64se_pkg::t_group    o_rdata,
    output b64se_pkg::t_q_status o_status
);
    import b64se_pkg::*;

    localparam int PtrW = $clog2(QDepth);
    localparam int CntW = $clog2(QDepth + 1);

    t_group             r_mem [QDepth];
    logic [PtrW-1:0]    r_wptr, r_rptr;
    logic [CntW-1:0]    r_cnt;
    logic               do_wr, do_rd;

    assign o_status.full  = (r_cnt == CntW'(QDepth));
    assign o_status.empty = (r_cnt == '0);
    assign do_wr   = i_wr && !o_status.full;
    assign do_rd   = i_rd && !o_status.empty;
    assign o_rdata = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_wr) begin
                r_wptr <= (r_wptr == PtrW'(QDepth - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (do_rd) begin
                r_rptr <= (r_rptr == PtrW'(QDepth - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({do_wr, do_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/core/b64se_back.sv
// Back end: splits each group into four characters and drives the output register.
// Depends on b64se_pkg.
module b64se_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  b64se_pkg::t_group    i_grp,
    input  b64se_pkg::t_q_status i_q_status,
    output logic                 o_grp_pop,
    input  logic                 i_pop,
    output logic                 o_empty,
    output b64se_pkg::t_out_item o_out_item
);
    import b64se_pkg::*;

    t_group     r_grp;
    logic       r_busy;
    logic [1:0] r_idx;
    logic       r_out_valid;
    t_out_item  r_out;
    logic       adv, take;
    logic [5:0] sextet;
    t_out_item  n_out;

    // output register frees when empty or being taken
    assign adv       = !r_out_valid || i_pop;
    assign take      = (!r_busy || (adv && r_idx == 2'd3)) && !i_q_status.empty;
    assign o_grp_pop = take;

    always_comb begin
        case (r_idx)
            2'd0:    sextet = r_grp.bits[23:18];
            2'd1:    sextet = r_grp.bits[17:12];
            2'd2:    sextet = r_grp.bits[11:6];
            default: sextet = r_grp.bits[5:0];
        endcase
        n_out.out_char = b64_char(sextet);
        if ((r_idx == 2'd3 && r_grp.pad != 2'd0) || (r_idx == 2'd2 && r_grp.pad == 2'd2)) begin
            n_out.out_char = PadChar;
        end
        n_out.last_char = r_grp.last && (r_idx == 2'd3);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
        if (take) begin
            r_grp <= i_grp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_out_valid <= r_busy;
            end
            if (take) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
            end else if (adv && r_busy) begin
                r_idx <= r_idx + 1'b1;
                if (r_idx == 2'd3) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_empty    = !r_out_valid;
    assign o_out_item = r_out;

endmodule

### rtl/core/b64se_checker.sv
// Port-level checker for the Base64 stream encoder, bound to the top level.
// Depends on b64se_pkg and assert_macros.svh.
`include "assert_macros.svh"

module b64se_port_props (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_push,
    input b64se_pkg::t_in_item  i_in_item,
    input logic                 o_full,
    input logic                 i_pop,
    input logic                 o_empty,
    input b64se_pkg::t_out_item o_out_item
);
    import b64se_pkg::*;

    logic out_take, out_pad;

    assign out_take = i_pop && !o_empty;
    assign out_pad  = !o_empty && (o_out_item.out_char == PadChar);

    // reset drops the waiting result
    `ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> o_empty)

    // a stalled result holds
    `ASSERT_CLK(a_hold, i_clk, i_rst_n, (!o_empty && !i_pop) |=> (!o_empty && $stable(o_out_item)))

    // a first '=' is followed at once by a final '='
    `ASSERT_CLK(a_pad_pair, i_clk, i_rst_n, (out_take && out_pad && !o_out_item.last_char) |=> (out_pad && o_out_item.last_char))

    // a waiting result is always fully defined
    `ASSERT_CLK(a_known, i_clk, i_rst_n, !o_empty |-> !$isunknown(o_out_item))

endmodule

bind base64_stream_encoder_unit b64se_port_props u_b64se_port_props (.*);
